// ===== hw/rtl/tmbc_pkg.sv =====
// tmbc_pkg: shared types and constants of the tile map box collision block
// no dependencies; imported by tile_map_box_collision
`default_nettype none

package tmbc_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOLID_MASK = 2'd2;

  // configuration widths and reset values
  localparam int unsigned DIM_CFG_W  = 8;
  localparam int unsigned MASK_W     = 64;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [DIM_CFG_W-1:0] MAP_DIM_RST    = 8'd1;
  localparam logic [MASK_W-1:0]    SOLID_MASK_RST = 64'h8000_0000_0000_0303;

  // word field widths
  localparam int unsigned COORD_W = 7;
  localparam int unsigned CODE_W  = 6;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned SIZE_W  = 12;

  // clamped map size holds up to 256 tiles; pixel maths carries sign headroom
  localparam int unsigned DIM_W = 9;
  localparam int unsigned PIX_W = 19;

  // item kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CLAMP,
    ST_SCAN,
    ST_CHECK
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tmbc_tile_ram.sv =====
// tmbc_tile_ram: single-port synchronous tile store, registered read data
// no dependencies; used by tile_map_box_collision
`default_nettype none

module tmbc_tile_ram #(
  parameter int unsigned ADDR_W = 14,
  parameter int unsigned DATA_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tile_map_box_collision.sv =====
// tile_map_box_collision: tile store with box collision query
// depends on tmbc_pkg and tmbc_tile_ram
//
//   channel  | handshake         | payload
//   ---------+-------------------+-----------------------------------------------
//   input    | start / busy      | in_action, in_tile_*, in_box_*
//   result   | out_valid strobe  | out_hit, out_was_query
//   config   | cfg_we            | cfg_index, cfg_data
//
// A write word is acknowledged from ST_WRITE. A query word passes ST_CLAMP,
// then ST_SCAN reads the covered tiles and stops at the first solid one,
// else ST_CHECK takes the last read; empty or off-map boxes answer in ST_CLAMP.
// The single-port tile RAM gives one tile read a cycle, which sets the scan.
// Reset clears the control and config registers; the tile store keeps no reset.
// The result strobe lasts one cycle and cannot be held off by the receiver.
`default_nettype none

module tile_map_box_collision #(
  parameter int unsigned MAP_DIM    = 128,
  parameter int unsigned TILE_SHIFT = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_action,
  input  logic [tmbc_pkg::COORD_W-1:0]        in_tile_col,
  input  logic [tmbc_pkg::COORD_W-1:0]        in_tile_row,
  input  logic [tmbc_pkg::CODE_W-1:0]         in_tile_code,
  input  logic signed [tmbc_pkg::POS_W-1:0]   in_box_left,
  input  logic signed [tmbc_pkg::POS_W-1:0]   in_box_top,
  input  logic [tmbc_pkg::SIZE_W-1:0]         in_box_width,
  input  logic [tmbc_pkg::SIZE_W-1:0]         in_box_height,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic                                out_was_query,
  input  logic                                cfg_we,
  input  logic [tmbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import tmbc_pkg::*;

  localparam int unsigned AW     = $clog2(MAP_DIM);
  localparam int unsigned RAM_AW = 2 * AW;

  // configuration registers
  logic [DIM_CFG_W-1:0] map_w_r;
  logic [DIM_CFG_W-1:0] map_h_r;
  logic [MASK_W-1:0]    solid_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r      <= MAP_DIM_RST;
      map_h_r      <= MAP_DIM_RST;
      solid_mask_r <= SOLID_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_w_r      <= cfg_data[DIM_CFG_W-1:0];
        CFG_MAP_HEIGHT: map_h_r      <= cfg_data[DIM_CFG_W-1:0];
        CFG_SOLID_MASK: solid_mask_r <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and control registers
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_hit_r, out_hit_nxt;
  logic   out_wq_r, out_wq_nxt;
  logic   rd_pend_r, rd_pend_nxt;

  // captured word
  logic                     action_r;
  logic [COORD_W-1:0]       col_r;
  logic [COORD_W-1:0]       row_r;
  logic [CODE_W-1:0]        code_r;
  logic signed [POS_W-1:0]  left_r;
  logic signed [POS_W-1:0]  top_r;
  logic [SIZE_W-1:0]        width_r;
  logic [SIZE_W-1:0]        height_r;

  // scan range and position
  logic [AW-1:0] sx_r, sx_nxt;
  logic [AW-1:0] ex_r, ex_nxt;
  logic [AW-1:0] sy_r, sy_nxt;
  logic [AW-1:0] ey_r, ey_nxt;
  logic [AW-1:0] x_r, x_nxt;
  logic [AW-1:0] y_r, y_nxt;

  logic accept;
  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_action;
      col_r    <= in_tile_col;
      row_r    <= in_tile_row;
      code_r   <= in_tile_code;
      left_r   <= in_box_left;
      top_r    <= in_box_top;
      width_r  <= in_box_width;
      height_r <= in_box_height;
    end
  end

  // map size clamped to 1 .. MAP_DIM tiles
  logic [DIM_W-1:0] mw_c, mh_c;

  always_comb begin
    if (map_w_r == '0) begin
      mw_c = DIM_W'(1);
    end else if (DIM_W'(map_w_r) > DIM_W'(MAP_DIM)) begin
      mw_c = DIM_W'(MAP_DIM);
    end else begin
      mw_c = DIM_W'(map_w_r);
    end
    if (map_h_r == '0) begin
      mh_c = DIM_W'(1);
    end else if (DIM_W'(map_h_r) > DIM_W'(MAP_DIM)) begin
      mh_c = DIM_W'(MAP_DIM);
    end else begin
      mh_c = DIM_W'(map_h_r);
    end
  end

  // box clamped to the map in pixels, then turned into a tile range
  logic signed [PIX_W-1:0] left_s, top_s, right_s, bottom_s;
  logic signed [PIX_W-1:0] mright, mbottom;
  logic signed [PIX_W-1:0] left_c, top_c, right_c, bottom_c;
  logic signed [PIX_W-1:0] right_m1, bottom_m1;
  logic [PIX_W-1:0]        sx_sh, sy_sh, ex_sh, ey_sh;
  logic                    box_empty, box_outside;

  always_comb begin
    left_s    = {{(PIX_W-POS_W){left_r[POS_W-1]}}, left_r};
    top_s     = {{(PIX_W-POS_W){top_r[POS_W-1]}}, top_r};
    right_s   = left_s + $signed({{(PIX_W-SIZE_W){1'b0}}, width_r});
    bottom_s  = top_s + $signed({{(PIX_W-SIZE_W){1'b0}}, height_r});
    mright    = $signed({{(PIX_W-DIM_W){1'b0}}, mw_c} << TILE_SHIFT);
    mbottom   = $signed({{(PIX_W-DIM_W){1'b0}}, mh_c} << TILE_SHIFT);
    left_c    = left_s[PIX_W-1] ? '0 : left_s;
    top_c     = top_s[PIX_W-1] ? '0 : top_s;
    right_c   = (right_s > mright) ? mright : right_s;
    bottom_c  = (bottom_s > mbottom) ? mbottom : bottom_s;
    right_m1  = right_c - $signed(PIX_W'(1));
    bottom_m1 = bottom_c - $signed(PIX_W'(1));
    sx_sh     = PIX_W'(left_c) >> TILE_SHIFT;
    sy_sh     = PIX_W'(top_c) >> TILE_SHIFT;
    ex_sh     = PIX_W'(right_m1) >> TILE_SHIFT;
    ey_sh     = PIX_W'(bottom_m1) >> TILE_SHIFT;
    box_empty   = (width_r == '0) || (height_r == '0);
    box_outside = (left_c >= right_c) || (top_c >= bottom_c);
  end

  // tile store
  logic [DIM_W-1:0]  col_ext, row_ext;
  logic              wr_in_map;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [CODE_W-1:0] ram_rdata;
  logic              tile_solid;

  assign col_ext    = DIM_W'(col_r);
  assign row_ext    = DIM_W'(row_r);
  assign wr_in_map  = (col_ext < DIM_W'(MAP_DIM)) && (row_ext < DIM_W'(MAP_DIM));
  assign ram_addr   = (state_r == ST_WRITE) ? {row_ext[AW-1:0], col_ext[AW-1:0]}
                                            : {y_r, x_r};
  assign tile_solid = solid_mask_r[ram_rdata];

  tmbc_tile_ram #(
    .ADDR_W (RAM_AW),
    .DATA_W (CODE_W)
  ) u_tile_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (code_r),
    .rdata (ram_rdata)
  );

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    out_wq_nxt    = out_wq_r;
    rd_pend_nxt   = 1'b0;
    ram_we        = 1'b0;
    sx_nxt        = sx_r;
    ex_nxt        = ex_r;
    sy_nxt        = sy_r;
    ey_nxt        = ey_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_action == ACT_WRITE) ? ST_WRITE : ST_CLAMP;
        end
      end
      ST_WRITE: begin
        ram_we        = wr_in_map;
        out_valid_nxt = 1'b1;
        out_hit_nxt   = 1'b0;
        out_wq_nxt    = 1'b0;
        state_nxt     = ST_IDLE;
      end
      ST_CLAMP: begin
        sx_nxt = sx_sh[AW-1:0];
        ex_nxt = ex_sh[AW-1:0];
        sy_nxt = sy_sh[AW-1:0];
        ey_nxt = ey_sh[AW-1:0];
        x_nxt  = sx_sh[AW-1:0];
        y_nxt  = sy_sh[AW-1:0];
        out_wq_nxt = (action_r == ACT_QUERY);
        if (box_empty || box_outside) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = !box_empty;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_pend_r && tile_solid) begin
          // solid tile seen, stop early
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          rd_pend_nxt = 1'b1;
          if (x_r == ex_r) begin
            x_nxt = sx_r;
            y_nxt = y_r + AW'(1);
            if (y_r == ey_r) begin
              state_nxt = ST_CHECK;
            end
          end else begin
            x_nxt = x_r + AW'(1);
          end
        end
      end
      ST_CHECK: begin
        // last tile read returns here
        out_valid_nxt = 1'b1;
        out_hit_nxt   = tile_solid;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
    out_wq_r  <= out_wq_nxt;
    sx_r      <= sx_nxt;
    ex_r      <= ex_nxt;
    sy_r      <= sy_nxt;
    ey_r      <= ey_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_was_query = out_wq_r;

  // checks
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) != ST_IDLE))
    else $error("result strobe without an item in work");

  a_write_ack_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wq_r) |-> !out_hit_r)
    else $error("write acknowledge reports a hit");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((x_r <= ex_r) && (y_r <= ey_r)))
    else $error("scan position beyond tile range");

  a_check_has_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> rd_pend_r)
    else $error("final check without a pending tile read");

endmodule

`default_nettype wire
